// ----- rtl/obsa_pkg.sv -----
// Shared types and constants of the occupancy bitmap spacing allocator.
// No dependencies; the gap unit, scan sequencer and top import this package.
`default_nettype none

package obsa_pkg;

  // Fixed widths of the bitmap and its fields
  localparam int MAP_W    = 64;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int SLOT_MAX = 64;

  typedef enum logic [1:0] {
    CMD_QUERY  = 2'd0,
    CMD_OCCUPY = 2'd1,
    CMD_VACATE = 2'd2,
    CMD_LOAD   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_SAME  = 2'd2
  } status_t;

  // Snapshot handed to the scan sequencer when an item is accepted
  typedef struct packed {
    logic [MAP_W-1:0] map;
    logic [CNT_W-1:0] n;
    logic [IDX_W-1:0] last_pos;
    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             occ;
    status_t          status;
  } obsa_start_t;

endpackage

`default_nettype wire

// ----- rtl/obsa_in_if.sv -----
// Command channel of the allocator: valid/ready handshake and the command item.
// No dependencies.
`default_nettype none

interface obsa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [5:0]  slot_index;
  logic [63:0] load_bits;

  modport source (output valid, cmd, slot_index, load_bits, input ready);
  modport sink   (input valid, cmd, slot_index, load_bits, output ready);
endinterface

`default_nettype wire

// ----- rtl/obsa_out_if.sv -----
// Result channel of the allocator: valid/ready handshake and the result item.
// No dependencies.
`default_nettype none

interface obsa_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       slot_occupied;
  logic [6:0] nearest_distance;
  logic [5:0] best_slot;
  logic       no_free_slot;

  modport source (output valid, status, slot_occupied, nearest_distance, best_slot,
                  no_free_slot, input ready);
  modport sink   (input valid, status, slot_occupied, nearest_distance, best_slot,
                  no_free_slot, output ready);
endinterface

`default_nettype wire

// ----- rtl/obsa_gap_unit.sv -----
// Shared subtract, halve, add and compare unit used by the scan sequencer.
// Depends on obsa_pkg.
`default_nettype none

module obsa_gap_unit
  import obsa_pkg::*;
(
  input  wire logic [CNT_W-1:0] op_a,
  input  wire logic [CNT_W-1:0] op_b,
  input  wire logic             halve,
  input  wire logic [CNT_W-1:0] cmp,
  output logic      [CNT_W-1:0] diff,
  output logic      [CNT_W-1:0] sum,
  output logic                  gt
);

  logic [CNT_W-1:0] raw;

  // Gap length, optionally halved to the midpoint offset
  assign raw  = op_a - op_b;
  assign diff = halve ? (raw >> 1) : raw;
  // Slot reached from the base by the offset
  assign sum  = op_b + diff;
  // Candidate beats the running value
  assign gt   = diff > cmp;

endmodule

`default_nettype wire

// ----- rtl/obsa_scan_ctrl.sv -----
// Sequencer that scans a bitmap snapshot one slot a cycle through the gap unit
// and holds the result item. Depends on obsa_pkg, obsa_out_if, obsa_gap_unit.
`default_nettype none

module obsa_scan_ctrl
  import obsa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire obsa_start_t start_info,
  output logic             idle,
  obsa_out_if.source       out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_DNEXT,
    S_DPREV,
    S_DONE
  } state_t;

  state_t           state_r;
  logic [MAP_W-1:0] map_r;
  logic [CNT_W-1:0] n_r;
  logic [IDX_W-1:0] last_pos_r;
  logic [IDX_W-1:0] idx_r;
  logic             in_range_r;
  status_t          status_r;
  logic             occ_r;
  logic [IDX_W-1:0] pos_r;
  logic [IDX_W-1:0] j_r;
  logic [IDX_W-1:0] last_r;
  logic             seen_r;
  logic             free_seen_r;
  logic [IDX_W-1:0] prev_r;
  logic             prev_found_r;
  logic [IDX_W-1:0] next_r;
  logic             next_found_r;
  logic [IDX_W-1:0] best_r;
  logic [CNT_W-1:0] max_r;
  logic [CNT_W-1:0] dist_r;

  logic [1:0]       out_status_r;
  logic             out_occ_r;
  logic [CNT_W-1:0] out_dist_r;
  logic [IDX_W-1:0] out_best_r;
  logic             out_no_free_r;

  logic [CNT_W-1:0] op_a;
  logic [CNT_W-1:0] op_b;
  logic             halve;
  logic [CNT_W-1:0] cmp;
  logic [CNT_W-1:0] diff;
  logic [CNT_W-1:0] sum;
  logic             gt;
  logic             bit_occ;
  logic [IDX_W-1:0] cand_slot;
  logic [CNT_W-1:0] dist_fin;

  obsa_gap_unit u_gap (
    .op_a  (op_a),
    .op_b  (op_b),
    .halve (halve),
    .cmp   (cmp),
    .diff  (diff),
    .sum   (sum),
    .gt    (gt)
  );

  assign bit_occ = map_r[pos_r];

  // Steer the shared unit by sequencer step
  always_comb begin
    op_a      = {1'b0, j_r};
    op_b      = '0;
    halve     = 1'b0;
    cmp       = max_r;
    cand_slot = '0;
    case (state_r)
      S_SCAN: begin
        // Leading gap: distance j at slot 0; inner gap: midpoint after last
        op_a      = {1'b0, j_r};
        op_b      = seen_r ? {1'b0, last_r} : '0;
        halve     = seen_r;
        cand_slot = seen_r ? sum[IDX_W-1:0] : '0;
      end
      S_TAIL: begin
        op_a      = {1'b0, last_pos_r};
        op_b      = {1'b0, last_r};
        cand_slot = sum[IDX_W-1:0];
      end
      S_DNEXT: begin
        op_a = {1'b0, next_r};
        op_b = {1'b0, idx_r};
      end
      S_DPREV: begin
        op_a = {1'b0, idx_r};
        op_b = {1'b0, prev_r};
        cmp  = dist_r;
      end
      default: begin
        op_a = {1'b0, j_r};
      end
    endcase
  end

  // Nearer of the two sides, or the previous choice
  assign dist_fin = (prev_found_r && !gt) ? diff : dist_r;

  // Sequencer state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            map_r        <= start_info.map;
            n_r          <= start_info.n;
            last_pos_r   <= start_info.last_pos;
            idx_r        <= start_info.idx;
            in_range_r   <= start_info.in_range;
            occ_r        <= start_info.occ;
            status_r     <= start_info.status;
            pos_r        <= start_info.last_pos;
            j_r          <= '0;
            last_r       <= '0;
            seen_r       <= 1'b0;
            free_seen_r  <= 1'b0;
            prev_r       <= '0;
            prev_found_r <= 1'b0;
            next_r       <= '0;
            next_found_r <= 1'b0;
            best_r       <= '0;
            max_r        <= '0;
            state_r      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (bit_occ) begin
            if (gt) begin
              max_r  <= diff;
              best_r <= cand_slot;
            end
            last_r <= j_r;
            seen_r <= 1'b1;
            if (j_r <= idx_r) begin
              prev_r       <= j_r;
              prev_found_r <= 1'b1;
            end
            if (j_r >= idx_r && !next_found_r) begin
              next_r       <= j_r;
              next_found_r <= 1'b1;
            end
          end else begin
            free_seen_r <= 1'b1;
          end
          if (j_r == last_pos_r) begin
            state_r <= S_TAIL;
          end else begin
            j_r   <= j_r + 1'b1;
            pos_r <= pos_r - 1'b1;
          end
        end
        S_TAIL: begin
          // Trailing gap ends at the last slot
          if (seen_r && gt) begin
            max_r  <= diff;
            best_r <= cand_slot;
          end
          state_r <= S_DNEXT;
        end
        S_DNEXT: begin
          dist_r  <= next_found_r ? diff : n_r;
          state_r <= S_DPREV;
        end
        S_DPREV: begin
          dist_r        <= dist_fin;
          out_status_r  <= status_r;
          out_occ_r     <= occ_r;
          out_dist_r    <= in_range_r ? dist_fin : '0;
          out_best_r    <= free_seen_r ? best_r : '0;
          out_no_free_r <= !free_seen_r;
          state_r       <= S_DONE;
        end
        S_DONE: begin
          if (out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign idle                    = (state_r == S_IDLE);
  assign out_ch.valid            = (state_r == S_DONE);
  assign out_ch.status           = out_status_r;
  assign out_ch.slot_occupied    = out_occ_r;
  assign out_ch.nearest_distance = out_dist_r;
  assign out_ch.best_slot        = out_best_r;
  assign out_ch.no_free_slot     = out_no_free_r;

`ifndef NO_ASSERTIONS
  // Slot and position counters stay mirrored during the scan
  a_scan_counters: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> (j_r + pos_r) == last_pos_r)
    else $error("scan counters out of step");

  // An occupied addressed slot is at distance zero
  a_occ_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.slot_occupied |-> out_ch.nearest_distance == '0)
    else $error("occupied slot reports non-zero distance");

  // A full bitmap reports slot 0 as best
  a_full_best: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.no_free_slot |-> out_ch.best_slot == '0)
    else $error("full bitmap with non-zero best slot");

  // Distance never exceeds the slot count
  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.nearest_distance <= n_r)
    else $error("distance beyond slot count");

  // A new item only starts while the sequencer is idle
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == S_IDLE)
    else $error("item started while busy");
`endif

endmodule

`default_nettype wire

// ----- rtl/occupancy_bitmap_spacing_allocator_top.sv -----
// Allocator top: a result item is valid once the sequencer has walked the slots in
// use (n, 1 to 64) and then the trailing gap and both nearest distances; it walks
// one slot a cycle through a single shared subtract/compare unit.
// Ready returns in the cycle after the result is taken; until then no new item is taken.
// Reset (synchronous, active low) empties the bitmap and sets slot_count to 64.
`default_nettype none

module occupancy_bitmap_spacing_allocator_top
  import obsa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CNT_W-1:0] cfg_wr_data,
  obsa_in_if.sink               in_ch,
  obsa_out_if.source            out_ch
);

  logic [CNT_W-1:0] slot_count_r;
  logic [MAP_W-1:0] occupancy_r;
  logic [MAP_W-1:0] occupancy_nxt;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] last_pos;
  logic [CNT_W-1:0] bit_pos;
  logic [MAP_W-1:0] bit_mask;
  logic             in_range;
  logic             occ;
  logic             accept;
  logic             idle;
  cmd_t             cmd;
  status_t          status;
  obsa_start_t      start_info;

  // Hold the slot count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= CNT_W'(SLOT_MAX);
    end else if (cfg_wr_en) begin
      slot_count_r <= cfg_wr_data;
    end
  end

  // Clamp the slot count to 1 .. SLOT_MAX
  always_comb begin
    if (slot_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (slot_count_r > CNT_W'(SLOT_MAX)) begin
      n_eff = CNT_W'(SLOT_MAX);
    end else begin
      n_eff = slot_count_r;
    end
  end

  assign accept   = in_ch.valid && in_ch.ready;
  assign cmd      = cmd_t'(in_ch.cmd);
  assign last_pos = n_eff - CNT_W'(1);
  assign bit_pos  = last_pos - {1'b0, in_ch.slot_index};
  assign in_range = {1'b0, in_ch.slot_index} < n_eff;
  assign occ      = in_range && occupancy_r[bit_pos[IDX_W-1:0]];
  assign bit_mask = MAP_W'(1) << bit_pos[IDX_W-1:0];

  // Decode the command into status and the updated bitmap
  always_comb begin
    status        = STS_OK;
    occupancy_nxt = occupancy_r;
    case (cmd)
      CMD_QUERY: begin
        status = in_range ? STS_OK : STS_RANGE;
      end
      CMD_OCCUPY: begin
        if (!in_range) begin
          status = STS_RANGE;
        end else if (occ) begin
          status = STS_SAME;
        end else begin
          occupancy_nxt = occupancy_r | bit_mask;
        end
      end
      CMD_VACATE: begin
        if (!in_range) begin
          status = STS_RANGE;
        end else if (!occ) begin
          status = STS_SAME;
        end else begin
          occupancy_nxt = occupancy_r & ~bit_mask;
        end
      end
      default: begin
        occupancy_nxt = in_ch.load_bits;
      end
    endcase
  end

  // Update the bitmap as the item is taken; the scan works on the old copy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occupancy_r <= '0;
    end else if (accept) begin
      occupancy_r <= occupancy_nxt;
    end
  end

  always_comb begin
    start_info.map      = occupancy_r;
    start_info.n        = n_eff;
    start_info.last_pos = last_pos[IDX_W-1:0];
    start_info.idx      = in_ch.slot_index;
    start_info.in_range = in_range;
    start_info.occ      = occ;
    start_info.status   = status;
  end

  assign in_ch.ready = idle;

  obsa_scan_ctrl u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (accept),
    .start_info (start_info),
    .idle       (idle),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
